// ----- src/qvtd_pkg.sv -----
// Shared types and constants for the QUIC varint TLV deframer.
// No dependencies; every module of the block imports this package.
package qvtd_pkg;

  localparam int unsigned TagWidth     = 62;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] VarintLowMask  = 8'h3F;
  localparam int unsigned VarintSizeShift = 6;

  // payload_status codes.
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_CLEAN   = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } qvtd_in_t;

  typedef struct packed {
    logic [TagWidth-1:0] entry_tag;
    logic [7:0]          value_byte;
    logic                byte_is_value;
    logic                entry_done;
    logic [1:0]          payload_status;
  } qvtd_out_t;

  // A byte after classification, as it waits in the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic [5:0] low6;
    logic [2:0] extra_bytes;
  } qvtd_cls_t;

  // Front to back handshake group.
  typedef struct packed {
    logic      valid;
    qvtd_cls_t item;
  } qvtd_q_t;

  typedef enum logic [4:0] {
    PH_TAG_FIRST = 5'b00001,
    PH_TAG_REST  = 5'b00010,
    PH_LEN_FIRST = 5'b00100,
    PH_LEN_REST  = 5'b01000,
    PH_VALUE     = 5'b10000
  } qvtd_phase_t;

  // Bytes that follow the first byte of a varint, from its size code.
  function automatic logic [2:0] varint_extra(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd3;
      2'd3:    n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- src/qvtd_front.sv -----
// Front end of the deframer: takes input bytes, classifies them and queues them.
// Depends on qvtd_pkg.
module qvtd_front #(
  parameter int unsigned DEPTH = qvtd_pkg::QueueDepthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qvtd_pkg::qvtd_in_t in_data,
  output qvtd_pkg::qvtd_q_t  q_out,
  input  logic              q_pop
);
  import qvtd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  qvtd_cls_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  qvtd_cls_t         cls;
  logic              wr_en;
  logic              rd_en;

  always_comb begin
    cls.data_byte   = in_data.data_byte;
    cls.last        = in_data.end_of_payload;
    cls.low6        = 6'(in_data.data_byte & VarintLowMask);
    cls.extra_bytes = varint_extra(in_data.data_byte[VarintSizeShift +: 2]);
  end

  assign in_ready     = (count_r != CW'(DEPTH));
  assign wr_en        = in_valid && in_ready;
  assign rd_en        = q_pop && (count_r != '0);
  assign q_out.valid  = (count_r != '0);
  assign q_out.item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_r) + CW'($past(wr_en)) - CW'($past(rd_en)))
    else $error("queue occupancy does not follow writes and reads");

endmodule

// ----- src/qvtd_back.sv -----
// Back end of the deframer: the TLV parser and the result register.
// Depends on qvtd_pkg; fed by qvtd_front.
module qvtd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  qvtd_pkg::qvtd_q_t   q_in,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output qvtd_pkg::qvtd_out_t out_data
);
  import qvtd_pkg::*;

  qvtd_phase_t         phase_r, phase_nxt;
  logic [2:0]          vbl_r, vbl_nxt;
  logic [TagWidth-1:0] acc_r, acc_nxt;
  logic [TagWidth-1:0] tag_r, tag_nxt;
  logic [TagWidth-1:0] vleft_r, vleft_nxt;
  logic                out_valid_r;
  qvtd_out_t           out_data_r, res;
  logic [TagWidth-1:0] acc_more;
  logic [2:0]          vbl_more;
  qvtd_cls_t           it;

  assign it        = q_in.item;
  assign q_pop     = q_in.valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A following varint byte shifts in; the top eight bits of the accumulator fall off.
  assign acc_more = {acc_r[TagWidth-9:0], it.data_byte};
  assign vbl_more = vbl_r - 3'd1;

  always_comb begin
    phase_nxt = phase_r;
    vbl_nxt   = vbl_r;
    acc_nxt   = acc_r;
    tag_nxt   = tag_r;
    vleft_nxt = vleft_r;
    res       = '0;

    case (phase_r)
      PH_TAG_REST: begin
        acc_nxt = acc_more;
        vbl_nxt = vbl_more;
        if (vbl_more == 3'd0) begin
          tag_nxt       = acc_more;
          phase_nxt     = PH_LEN_FIRST;
          res.entry_tag = acc_more;
        end
      end
      PH_LEN_FIRST: begin
        res.entry_tag = tag_r;
        acc_nxt       = TagWidth'(it.low6);
        vbl_nxt       = it.extra_bytes;
        if (it.extra_bytes == 3'd0) begin
          vleft_nxt = TagWidth'(it.low6);
          if (it.low6 == 6'd0) begin
            phase_nxt      = PH_TAG_FIRST;
            res.entry_done = 1'b1;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end else begin
          phase_nxt = PH_LEN_REST;
        end
      end
      PH_LEN_REST: begin
        res.entry_tag = tag_r;
        acc_nxt       = acc_more;
        vbl_nxt       = vbl_more;
        if (vbl_more == 3'd0) begin
          vleft_nxt = acc_more;
          if (acc_more == '0) begin
            phase_nxt      = PH_TAG_FIRST;
            res.entry_done = 1'b1;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        res.entry_tag     = tag_r;
        res.value_byte    = it.data_byte;
        res.byte_is_value = 1'b1;
        vleft_nxt         = vleft_r - 1'b1;
        if (vleft_r == TagWidth'(1)) begin
          res.entry_done = 1'b1;
          phase_nxt      = PH_TAG_FIRST;
        end
      end
      default: begin
        acc_nxt = TagWidth'(it.low6);
        vbl_nxt = it.extra_bytes;
        if (it.extra_bytes == 3'd0) begin
          tag_nxt       = TagWidth'(it.low6);
          phase_nxt     = PH_LEN_FIRST;
          res.entry_tag = TagWidth'(it.low6);
        end else begin
          phase_nxt = PH_TAG_REST;
        end
      end
    endcase

    // The final byte reports where the parser stopped, then starts afresh.
    if (it.last) begin
      if (phase_nxt == PH_TAG_FIRST) begin
        res.payload_status = ST_CLEAN;
      end else if (phase_nxt == PH_VALUE) begin
        res.payload_status = ST_OVERRUN;
      end else begin
        res.payload_status = ST_TRUNC;
      end
      phase_nxt = PH_TAG_FIRST;
      vbl_nxt   = '0;
      acc_nxt   = '0;
      tag_nxt   = '0;
      vleft_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG_FIRST;
      vbl_r       <= '0;
      acc_r       <= '0;
      tag_r       <= '0;
      vleft_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        vbl_r   <= vbl_nxt;
        acc_r   <= acc_nxt;
        tag_r   <= tag_nxt;
        vleft_r <= vleft_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VALUE |-> vleft_r != '0)
    else $error("value phase entered with no value bytes due");

  a_rest_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAG_REST || phase_r == PH_LEN_REST) |-> vbl_r != 3'd0)
    else $error("varint continuation phase with no bytes due");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && it.last |=> phase_r == PH_TAG_FIRST && vleft_r == '0 && tag_r == '0)
    else $error("parser not back at start after final byte");

  a_no_stray_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.byte_is_value |-> out_data_r.value_byte == 8'd0)
    else $error("value byte set on a non-value result");

endmodule

// ----- src/quic_varint_tlv_deframer.sv -----
// Top level of the QUIC varint TLV deframer.
// Depends on qvtd_pkg, qvtd_front and qvtd_back.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) carries one payload byte per
//   transfer, with end_of_payload set on the final byte. The result channel
//   (out_valid, out_ready, out_data) carries exactly one result per input byte,
//   in order: the tag of the entry the byte belongs to, the value byte when the
//   byte is part of a value, the entry-complete mark and, on the final byte,
//   how the payload ended.
//   A transferred byte is first written into the front queue; the parser step
//   then loads its result into the result register, from which the receiver
//   takes it.
//   Throughput: one byte per cycle while out_ready stays high.
//   The front queue holds QUEUE_DEPTH bytes. When the receiver stalls, the
//   result register holds, the queue fills and in_ready falls once it is full;
//   transfers resume at full rate once out_ready returns.
//   Reset (rst_n low, synchronous) empties the queue, drops out_valid and puts
//   the parser at the start of a payload. After each final byte the parser
//   also returns to that start.
module quic_varint_tlv_deframer #(
  parameter int unsigned QUEUE_DEPTH = qvtd_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qvtd_pkg::qvtd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qvtd_pkg::qvtd_out_t out_data
);
  import qvtd_pkg::*;

  qvtd_q_t q;
  logic    q_pop;

  qvtd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_out    (q),
    .q_pop    (q_pop)
  );

  qvtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for quic_varint_tlv_deframer: random TLV payloads under idling and stalls.
// Depends on qvtd_pkg and the deframer RTL; a predictor in this file computes every expected result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qvtd_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int ItemsPerPhase = 100;
  localparam int LongHoldCycles = 80;
  localparam int PhaseCount = 5;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  qvtd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  qvtd_out_t out_data;

  quic_varint_tlv_deframer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Bytes waiting to be offered, and results the deframer still owes.
  qvtd_in_t   pending_bytes[$];
  qvtd_out_t  expected_results[$];
  logic [7:0] frame_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int phase_items = 0;
  int idle_tab[PhaseCount] = '{0, 47, 0, 22, 0};
  int stall_tab[PhaseCount] = '{0, 0, 47, 22, 0};

  logic pressure_req = 1'b0;
  int   hold_cycles = 0;
  logic long_hold;
  assign long_hold = pressure_req && (hold_cycles < LongHoldCycles);

  // Predictor state.
  qvtd_phase_t frame_phase;
  logic [2:0]  vint_left;
  logic [61:0] vint_acc;
  logic [61:0] cur_tag;
  logic [61:0] val_left;

  task automatic reset_deframer();
    frame_phase = PH_TAG_FIRST;
    vint_left   = 3'd0;
    vint_acc    = '0;
    cur_tag     = '0;
    val_left    = '0;
  endtask

  // The length varint is complete: either the value follows or the entry is already over.
  task automatic load_length(output logic zero_len);
    val_left = vint_acc;
    zero_len = (val_left == '0);
    frame_phase = zero_len ? PH_TAG_FIRST : PH_VALUE;
  endtask

  task automatic deframe_byte(input qvtd_in_t item, output qvtd_out_t res);
    logic [7:0] b;
    logic [3:0] span;
    b    = item.data_byte;
    span = (4'd1 << b[7:6]) - 4'd1;
    res  = '0;
    case (frame_phase)
      PH_TAG_REST: begin
        vint_acc  = {vint_acc[53:0], b};
        vint_left = vint_left - 3'd1;
        if (vint_left == 3'd0) begin
          cur_tag       = vint_acc;
          frame_phase   = PH_LEN_FIRST;
          res.entry_tag = cur_tag;
        end
      end
      PH_LEN_FIRST: begin
        res.entry_tag = cur_tag;
        vint_acc      = {56'd0, b[5:0]};
        vint_left     = span[2:0];
        if (span == 4'd0) load_length(res.entry_done);
        else frame_phase = PH_LEN_REST;
      end
      PH_LEN_REST: begin
        res.entry_tag = cur_tag;
        vint_acc      = {vint_acc[53:0], b};
        vint_left     = vint_left - 3'd1;
        if (vint_left == 3'd0) load_length(res.entry_done);
      end
      PH_VALUE: begin
        res.entry_tag     = cur_tag;
        res.value_byte    = b;
        res.byte_is_value = 1'b1;
        val_left          = val_left - 62'd1;
        if (val_left == '0) begin
          res.entry_done = 1'b1;
          frame_phase    = PH_TAG_FIRST;
        end
      end
      default: begin
        vint_acc  = {56'd0, b[5:0]};
        vint_left = span[2:0];
        if (span == 4'd0) begin
          cur_tag       = vint_acc;
          frame_phase   = PH_LEN_FIRST;
          res.entry_tag = cur_tag;
        end else begin
          frame_phase = PH_TAG_REST;
        end
      end
    endcase
    if (item.end_of_payload) begin
      case (frame_phase)
        PH_TAG_FIRST: res.payload_status = ST_CLEAN;
        PH_VALUE:     res.payload_status = ST_OVERRUN;
        default:      res.payload_status = ST_TRUNC;
      endcase
      reset_deframer();
    end
  endtask

  // Payload construction.
  task automatic put_varint(input logic [63:0] v, input logic [1:0] code);
    int n;
    logic [7:0] b;
    n = 1 << code;
    for (int i = n - 1; i >= 0; i--) begin
      b = 8'(v >> (8 * i));
      if (i == n - 1) b[7:6] = code;
      frame_q.push_back(b);
    end
  endtask

  // A varint whose size code promises more bytes than are given.
  task automatic put_partial_varint();
    logic [1:0] code;
    int n;
    code = 2'($urandom_range(3, 1));
    n = 1 << code;
    frame_q.push_back({code, 6'($urandom)});
    repeat ($urandom_range(n - 2, 0)) frame_q.push_back(8'($urandom));
  endtask

  task automatic put_tag();
    int r;
    logic [1:0] code;
    r = $urandom_range(9);
    code = (r < 4) ? 2'd0 : (r < 7) ? 2'd1 : (r < 9) ? 2'd2 : 2'd3;
    put_varint({$urandom, $urandom}, code);
  endtask

  task automatic put_entry();
    int r;
    int len;
    put_tag();
    r = $urandom_range(9);
    len = (r < 3) ? 0 : (r < 9) ? $urandom_range(6, 1) : $urandom_range(40, 7);
    put_varint(64'(len), 2'($urandom_range(3)));
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  // Moves the assembled payload into the offer queue, marking its final byte.
  task automatic flush_payload();
    qvtd_in_t item;
    foreach (frame_q[i]) begin
      item.data_byte      = frame_q[i];
      item.end_of_payload = (i == frame_q.size() - 1);
      pending_bytes.push_back(item);
    end
    phase_items += frame_q.size();
    frame_q.delete();
  endtask

  task automatic gen_payload();
    int kind;
    int r;
    logic [63:0] len;
    logic [1:0] code;
    int max_vals;
    qvtd_in_t item;
    kind = $urandom_range(9);
    if (kind < 6) begin
      repeat ($urandom_range(4, 1)) put_entry();
    end else if (kind == 6) begin
      repeat ($urandom_range(2)) put_entry();
      r = $urandom_range(2);
      if (r == 0) begin
        put_partial_varint();
      end else begin
        put_tag();
        if (r == 2) put_partial_varint();
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(2)) put_entry();
      put_tag();
      if ($urandom_range(1) == 0) begin
        len  = 64'($urandom_range(10, 2));
        code = 2'($urandom_range(3));
      end else begin
        // A huge announced length; only a handful of value bytes follow.
        len  = {2'b00, $urandom, 30'($urandom)} | 64'd1;
        code = 2'd3;
      end
      put_varint(len, code);
      max_vals = (len - 1 > 5) ? 5 : int'(len - 1);
      repeat ($urandom_range(max_vals, 0)) frame_q.push_back(8'($urandom));
    end
    if (frame_q.size() != 0) begin
      flush_payload();
    end else begin
      // Unstructured bytes with scattered end marks; the last one always closes the payload.
      r = $urandom_range(12, 1);
      for (int i = 0; i < r; i++) begin
        item.data_byte      = 8'($urandom);
        item.end_of_payload = (i == r - 1) || ($urandom_range(99) < 15);
        pending_bytes.push_back(item);
      end
      phase_items += r;
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Driver: offers the next byte once the previous transfer has completed.
  always @(posedge clk) begin
    qvtd_out_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
      reset_deframer();
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data, predicted);
        expected_results.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted apart from the monitor.
  always @(posedge clk) begin
    if (long_hold) hold_cycles <= hold_cycles + 1;
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    qvtd_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatch_count++;
            $display({"%0t: mismatch, expected tag=%h val=%h isval=%b done=%b status=%0d,",
                      " actual tag=%h val=%h isval=%b done=%b status=%0d"}, $time,
                     want.entry_tag, want.value_byte, want.byte_is_value, want.entry_done,
                     want.payload_status, out_data.entry_tag, out_data.value_byte,
                     out_data.byte_is_value, out_data.entry_done, out_data.payload_status);
          end
        end
      end
      out_ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero-length entry, then a clean end.
    frame_q = '{8'h00, 8'h00};
    flush_payload();
    // Largest eight-byte tag, a one-byte value of all ones.
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF};
    flush_payload();
    // Payload ends on the first byte of a long tag.
    frame_q = '{8'hC0};
    flush_payload();
    // Announced length far beyond the payload.
    frame_q = '{8'h3F, 8'h7F, 8'hFF, 8'h55};
    flush_payload();
    // Ends inside a four-byte length, then right after a complete tag.
    frame_q = '{8'h05, 8'h80};
    flush_payload();
    frame_q = '{8'h07};
    flush_payload();
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      // The first phase opens with the receiver held off so the input queue fills.
      if (p == 0) pressure_req = 1'b1;
      phase_items = 0;
      while (phase_items < ItemsPerPhase) gen_payload();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- quic_varint_tlv_deframer.f -----
src/qvtd_pkg.sv
src/qvtd_front.sv
src/qvtd_back.sv
src/quic_varint_tlv_deframer.sv
tb/testbench.sv
